// ===== src/eapol_key_frame_classifier_top_macros.svh =====
// Assertion macros shared by the classifier modules.
// Each macro expects i_clk and i_rst_n in the scope where it is used.
`ifndef EAPOL_KEY_FRAME_CLASSIFIER_TOP_MACROS_SVH
`define EAPOL_KEY_FRAME_CLASSIFIER_TOP_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define EAKC_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define EAKC_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== src/eakc_pkg.sv =====
// Shared constants, types and the SNAP header table for the EAPOL-Key classifier.
// No dependencies.
package eakc_pkg;

    // Frame position counter saturates here.
    localparam int MAX_FRAME = 4095;
    localparam int POS_W     = $clog2(MAX_FRAME + 1);
    localparam int OFS_W     = 6;

    // Header layout.
    localparam int HDR_BASE      = 24;
    localparam int HDR_ADDR4_ADD = 6;
    localparam int HDR_QOS_ADD   = 2;
    localparam int RX_FIRST      = 4;
    localparam int TX_FIRST      = 10;
    localparam int ADDR_END      = 16;

    // LLC/SNAP and EAPOL layout, relative to the end of the MAC header.
    localparam int SNAP_LEN        = 8;
    localparam int EAPOL_TYPE_OFS  = 9;
    localparam int KEY_INFO_HI_OFS = 13;
    localparam int KEY_INFO_LO_OFS = 14;
    localparam int EAPOL_MIN_LEN   = 99;
    localparam int EAPOL_KEY_TYPE  = 3;

    typedef enum logic [2:0] {
        MSG_NONE = 3'd0,
        MSG_1    = 3'd1,
        MSG_2    = 3'd2,
        MSG_3    = 3'd3,
        MSG_4    = 3'd4
    } t_msg;

    // Per-frame summary handed from the tracker to the decoder.
    typedef struct packed {
        logic        is_data;
        logic        snap_ok;
        logic        len_ok;
        logic [7:0]  eapol_kind;
        logic [15:0] key_info;
        logic [47:0] rx_addr;
        logic [47:0] tx_addr;
    } t_frame_sum;

    // Expected LLC/SNAP EAPOL header bytes.
    function automatic logic [7:0] snap_byte(input logic [2:0] idx);
        logic [7:0] b;
        case (idx)
            3'd0:    b = 8'hAA;
            3'd1:    b = 8'hAA;
            3'd2:    b = 8'h03;
            3'd3:    b = 8'h00;
            3'd4:    b = 8'h00;
            3'd5:    b = 8'h00;
            3'd6:    b = 8'h88;
            3'd7:    b = 8'h8E;
            default: b = 8'h00;
        endcase
        return b;
    endfunction

endpackage

// ===== src/eakc_tracker.sv =====
// Per-frame byte tracker: position counter, header fields and EAPOL checks.
// Depends on eakc_pkg and the assertion macro header.
`include "eapol_key_frame_classifier_top_macros.svh"

module eakc_tracker
    import eakc_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_adv,
    input  logic [7:0]  i_byte,
    input  logic        i_last,
    input  logic        i_is_data,
    output t_frame_sum  o_sum
);

    localparam int REL_W = POS_W + 1;

    logic [POS_W-1:0] r_byte_position, n_byte_position;
    logic [7:0]       r_control_first, n_control_first;
    logic [47:0]      r_receiver_addr, n_receiver_addr;
    logic [47:0]      r_transmitter_addr, n_transmitter_addr;
    logic [OFS_W-1:0] r_header_offset, n_header_offset;
    logic             r_snap_match, n_snap_match;
    logic [7:0]       r_eapol_kind, n_eapol_kind;
    logic [15:0]      r_key_information, n_key_information;

    logic [OFS_W-1:0] w_off;
    logic [REL_W-1:0] w_pos_ext;
    logic [REL_W-1:0] w_off_ext;
    logic [REL_W-1:0] w_rel;
    logic             w_past_hdr;

    // The header length is settled on the second frame control byte.
    always_comb begin
        w_off = r_header_offset;
        if (r_byte_position == POS_W'(1)) begin
            w_off = OFS_W'(HDR_BASE)
                  + ((i_byte[1:0] == 2'b11) ? OFS_W'(HDR_ADDR4_ADD) : OFS_W'(0))
                  + ((r_control_first[7] && r_control_first[3]) ? OFS_W'(HDR_QOS_ADD)
                                                                 : OFS_W'(0));
        end
    end

    assign w_pos_ext  = {1'b0, r_byte_position};
    assign w_off_ext  = REL_W'(w_off);
    assign w_past_hdr = (w_pos_ext >= w_off_ext);
    assign w_rel      = w_pos_ext - w_off_ext;

    // Field capture and header checks for the current beat.
    always_comb begin
        n_control_first    = r_control_first;
        n_receiver_addr    = r_receiver_addr;
        n_transmitter_addr = r_transmitter_addr;
        n_header_offset    = r_header_offset;
        n_snap_match       = r_snap_match;
        n_eapol_kind       = r_eapol_kind;
        n_key_information  = r_key_information;
        n_byte_position    = r_byte_position;

        if (r_byte_position == '0) begin
            n_control_first = i_byte;
        end
        if (r_byte_position == POS_W'(1)) begin
            n_header_offset = w_off;
        end
        if (r_byte_position >= POS_W'(RX_FIRST) && r_byte_position < POS_W'(TX_FIRST)) begin
            n_receiver_addr = {r_receiver_addr[39:0], i_byte};
        end
        if (r_byte_position >= POS_W'(TX_FIRST) && r_byte_position < POS_W'(ADDR_END)) begin
            n_transmitter_addr = {r_transmitter_addr[39:0], i_byte};
        end
        if (w_past_hdr && w_rel < REL_W'(SNAP_LEN) && i_byte != snap_byte(w_rel[2:0])) begin
            n_snap_match = 1'b0;
        end
        if (w_past_hdr && w_rel == REL_W'(EAPOL_TYPE_OFS)) begin
            n_eapol_kind = i_byte;
        end
        if (w_past_hdr && w_rel == REL_W'(KEY_INFO_HI_OFS)) begin
            n_key_information = {i_byte, r_key_information[7:0]};
        end
        if (w_past_hdr && w_rel == REL_W'(KEY_INFO_LO_OFS)) begin
            n_key_information = {r_key_information[15:8], i_byte};
        end
        if (r_byte_position < POS_W'(MAX_FRAME)) begin
            n_byte_position = r_byte_position + POS_W'(1);
        end
    end

    // Summary of the frame as it stands after this beat.
    always_comb begin
        o_sum.is_data    = i_is_data;
        o_sum.snap_ok    = n_snap_match;
        o_sum.len_ok     = (w_pos_ext + REL_W'(1)) >= (w_off_ext + REL_W'(SNAP_LEN + EAPOL_MIN_LEN));
        o_sum.eapol_kind = n_eapol_kind;
        o_sum.key_info   = n_key_information;
        o_sum.rx_addr    = n_receiver_addr;
        o_sum.tx_addr    = n_transmitter_addr;
    end

    // State update; everything returns to its reset value after the last beat.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (i_adv && i_last)) begin
            r_byte_position    <= '0;
            r_control_first    <= '0;
            r_receiver_addr    <= '0;
            r_transmitter_addr <= '0;
            r_header_offset    <= OFS_W'(HDR_BASE);
            r_snap_match       <= 1'b1;
            r_eapol_kind       <= '0;
            r_key_information  <= '0;
        end else if (i_adv) begin
            r_byte_position    <= n_byte_position;
            r_control_first    <= n_control_first;
            r_receiver_addr    <= n_receiver_addr;
            r_transmitter_addr <= n_transmitter_addr;
            r_header_offset    <= n_header_offset;
            r_snap_match       <= n_snap_match;
            r_eapol_kind       <= n_eapol_kind;
            r_key_information  <= n_key_information;
        end
    end

    `EAKC_ASSERT_NEXT(a_pos_clears, (i_adv && i_last), (r_byte_position == '0),
        "Position did not return to zero after the last beat.")
    `EAKC_ASSERT_NOW(a_hdr_len, 1'b1,
        (r_header_offset == OFS_W'(24) || r_header_offset == OFS_W'(26) ||
         r_header_offset == OFS_W'(30) || r_header_offset == OFS_W'(32)),
        "Header length took an impossible value.")
    `EAKC_ASSERT_NEXT(a_pos_step,
        (i_adv && !i_last && r_byte_position < POS_W'(MAX_FRAME)),
        (r_byte_position == $past(r_byte_position) + POS_W'(1)),
        "Position did not advance on a non-final beat.")

endmodule

// ===== src/eakc_msg_decode.sv =====
// Key-information decoder: handshake message number and address roles.
// Depends on eakc_pkg.
module eakc_msg_decode
    import eakc_pkg::*;
(
    input  t_frame_sum  i_sum,
    output t_msg        o_msg,
    output logic [47:0] o_ap_addr,
    output logic [47:0] o_sta_addr
);

    logic w_install;
    logic w_ack;
    logic w_mic;
    logic w_secure;
    logic w_eligible;

    assign w_install  = i_sum.key_info[6];
    assign w_ack      = i_sum.key_info[7];
    assign w_mic      = i_sum.key_info[8];
    assign w_secure   = i_sum.key_info[9];
    assign w_eligible = i_sum.is_data && i_sum.snap_ok && i_sum.len_ok
                     && (i_sum.eapol_kind == 8'(EAPOL_KEY_TYPE));

    // Message number from the ack, mic, install and secure flags, in priority order.
    always_comb begin
        o_msg = MSG_NONE;
        if (w_eligible) begin
            if (w_ack && !w_mic) begin
                o_msg = MSG_1;
            end else if (!w_ack && w_mic && !w_install) begin
                o_msg = MSG_2;
            end else if (w_ack && w_mic && w_install) begin
                o_msg = MSG_3;
            end else if (!w_ack && w_mic && w_secure) begin
                o_msg = MSG_4;
            end
        end
    end

    // The access point sends messages 1 and 3; the station sends 2 and 4.
    always_comb begin
        case (o_msg)
            MSG_1, MSG_3: begin
                o_ap_addr  = i_sum.tx_addr;
                o_sta_addr = i_sum.rx_addr;
            end
            MSG_2, MSG_4: begin
                o_ap_addr  = i_sum.rx_addr;
                o_sta_addr = i_sum.tx_addr;
            end
            default: begin
                o_ap_addr  = '0;
                o_sta_addr = '0;
            end
        endcase
    end

endmodule

// ===== src/eapol_key_frame_classifier_top.sv =====
// Top level of the EAPOL-Key handshake message classifier.
// Depends on eakc_pkg, eakc_tracker, eakc_msg_decode and the macro header.
//
// Usage:
//   Input channel (i_valid/o_ready) carries one frame byte per beat, starting with
//   frame control, with i_last_byte marking the final byte and i_is_data_packet
//   giving the radio's data classification (sampled on the final byte).
//   Output channel (o_valid/i_ready) carries one result per frame: the handshake
//   message number (0 when the frame is not an EAPOL-Key handshake frame) and the
//   access point and station addresses (both zero for message 0).
// Timing:
//   A byte is registered on acceptance and processed from that register; o_valid rises
//   when the final byte moves on into the result register. One byte is accepted per
//   cycle while no final byte waits for a full output; the rate is set by the single
//   input register feeding the tracker, which updates its state once per beat.
// Stalls and reset:
//   When i_ready is low, the result stays in the output register; non-final bytes
//   still flow, and only a final byte waits until the output register is free.
//   A synchronous reset (i_rst_n low) drops both registers and returns the frame
//   state to the start of a frame.
`include "eapol_key_frame_classifier_top_macros.svh"

module eapol_key_frame_classifier_top
    import eakc_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [7:0]  i_frame_byte,
    input  logic        i_last_byte,
    input  logic        i_is_data_packet,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [2:0]  o_handshake_message,
    output logic [47:0] o_ap_address,
    output logic [47:0] o_station_address
);

    logic        r_in_valid;
    logic [7:0]  r_in_byte;
    logic        r_in_last;
    logic        r_in_data;

    logic        r_out_valid;
    logic [2:0]  r_out_msg;
    logic [47:0] r_out_ap;
    logic [47:0] r_out_sta;

    logic        w_out_free;
    logic        w_adv;
    t_frame_sum  w_sum;
    t_msg        w_msg;
    logic [47:0] w_ap;
    logic [47:0] w_sta;

    // A registered beat moves on unless it is a final byte facing a full output.
    assign w_out_free = !r_out_valid || i_ready;
    assign w_adv      = r_in_valid && (!r_in_last || w_out_free);
    assign o_ready    = !r_in_valid || w_adv;

    // Input register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_ready) begin
            r_in_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_in_byte <= i_frame_byte;
            r_in_last <= i_last_byte;
            r_in_data <= i_is_data_packet;
        end
    end

    eakc_tracker u_tracker (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_adv     (w_adv),
        .i_byte    (r_in_byte),
        .i_last    (r_in_last),
        .i_is_data (r_in_data),
        .o_sum     (w_sum)
    );

    eakc_msg_decode u_decode (
        .i_sum      (w_sum),
        .o_msg      (w_msg),
        .o_ap_addr  (w_ap),
        .o_sta_addr (w_sta)
    );

    // Result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_adv && r_in_last) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv && r_in_last) begin
            r_out_msg <= w_msg;
            r_out_ap  <= w_ap;
            r_out_sta <= w_sta;
        end
    end

    assign o_valid             = r_out_valid;
    assign o_handshake_message = r_out_msg;
    assign o_ap_address        = r_out_ap;
    assign o_station_address   = r_out_sta;

    `EAKC_ASSERT_NOW(a_no_msg_no_addr, (r_out_valid && r_out_msg == MSG_NONE),
        (r_out_ap == '0 && r_out_sta == '0),
        "Addresses given for a frame that is not a handshake frame.")
    `EAKC_ASSERT_NEXT(a_last_gives_result, (w_adv && r_in_last), r_out_valid,
        "Final byte advanced without a result.")
    `EAKC_ASSERT_NOW(a_final_waits, (r_in_valid && r_in_last && !w_out_free), !o_ready,
        "Input taken while a final byte waits for the output register.")

endmodule

// ===== bench/key_message_checker.sv =====
`timescale 1ns / 1ps
// Result checker for the EAPOL-Key classifier bench: follows both channels,
// predicts the result of every frame and compares it field by field. Depends on eakc_pkg.

module key_message_checker
    import eakc_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_byte_valid,
    input  logic        i_byte_ready,
    input  logic [7:0]  i_frame_byte,
    input  logic        i_last_byte,
    input  logic        i_is_data_packet,
    input  logic        i_res_valid,
    input  logic        i_res_ready,
    input  logic [2:0]  i_handshake_message,
    input  logic [47:0] i_ap_address,
    input  logic [47:0] i_station_address,
    output int          o_pending,
    output int          o_fail_count
);

    // LLC/SNAP header for EAPOL, first byte on the air in the top byte.
    localparam logic [63:0] LLC_SNAP_EAPOL = 64'hAAAA_0300_0000_888E;

    // Key information bit positions.
    localparam int KI_INSTALL = 6;
    localparam int KI_ACK     = 7;
    localparam int KI_MIC     = 8;
    localparam int KI_SECURE  = 9;

    typedef struct packed {
        logic [2:0]  msg;
        logic [47:0] ap;
        logic [47:0] sta;
    } t_key_result;

    // Per-frame state, rebuilt from the byte beats.
    logic [POS_W-1:0] pos_q;
    logic [7:0]       ctrl0_q;
    logic [47:0]      rx_addr_q;
    logic [47:0]      tx_addr_q;
    logic [OFS_W-1:0] hdr_len_q;
    logic             snap_ok_q;
    logic [7:0]       eapol_kind_q;
    logic [15:0]      key_info_q;

    // Results owed by the block, oldest first.
    t_key_result key_results_due[$];

    initial o_fail_count = 0;
    initial o_pending = 0;

    task automatic report_mismatch(input string what, input logic [47:0] want,
                                   input logic [47:0] got);
        o_fail_count = o_fail_count + 1;
        $display("%0t mismatch: %s: expected %0h, got %0h", $time, what, want, got);
    endtask

    task automatic clear_frame();
        pos_q        = '0;
        ctrl0_q      = '0;
        rx_addr_q    = '0;
        tx_addr_q    = '0;
        hdr_len_q    = OFS_W'(HDR_BASE);
        snap_ok_q    = 1'b1;
        eapol_kind_q = '0;
        key_info_q   = '0;
    endtask

    always @(posedge i_clk) begin : track
        int          pos;
        int          hdr;
        t_msg        msg;
        t_key_result due;
        logic        ack;
        logic        mic;
        logic        install;
        logic        secure;
        if (!i_rst_n) begin
            clear_frame();
            key_results_due.delete();
            o_pending <= 0;
        end else begin
            // A result beat is matched against the oldest frame still owed.
            if (i_res_valid && i_res_ready) begin
                if (key_results_due.size() == 0) begin
                    report_mismatch("result beat with no frame pending", '0,
                                    48'(i_handshake_message));
                end else begin
                    due = key_results_due.pop_front();
                    if (i_handshake_message !== due.msg)
                        report_mismatch("handshake message", 48'(due.msg),
                                        48'(i_handshake_message));
                    if (i_ap_address !== due.ap)
                        report_mismatch("ap address", due.ap, i_ap_address);
                    if (i_station_address !== due.sta)
                        report_mismatch("station address", due.sta, i_station_address);
                end
            end

            // A byte beat advances the frame state.
            if (i_byte_valid && i_byte_ready) begin
                pos = pos_q;
                hdr = hdr_len_q;
                if (pos == 0) begin
                    ctrl0_q = i_frame_byte;
                end else if (pos == 1) begin
                    hdr = HDR_BASE;
                    if (i_frame_byte[1:0] == 2'b11) hdr = hdr + HDR_ADDR4_ADD;
                    if (ctrl0_q[7] && ctrl0_q[3]) hdr = hdr + HDR_QOS_ADD;
                    hdr_len_q = OFS_W'(hdr);
                end

                if (pos >= RX_FIRST && pos < TX_FIRST)
                    rx_addr_q = {rx_addr_q[39:0], i_frame_byte};
                if (pos >= TX_FIRST && pos < ADDR_END)
                    tx_addr_q = {tx_addr_q[39:0], i_frame_byte};

                if (pos >= hdr && pos < hdr + SNAP_LEN &&
                    i_frame_byte != LLC_SNAP_EAPOL[63 - 8 * (pos - hdr) -: 8])
                    snap_ok_q = 1'b0;
                if (pos == hdr + EAPOL_TYPE_OFS) eapol_kind_q = i_frame_byte;
                if (pos == hdr + KEY_INFO_HI_OFS) key_info_q[15:8] = i_frame_byte;
                if (pos == hdr + KEY_INFO_LO_OFS) key_info_q[7:0] = i_frame_byte;

                if (!i_last_byte) begin
                    // The position counter sticks at the maximum frame length.
                    if (pos < MAX_FRAME) pos_q = pos_q + 1'b1;
                end else begin
                    ack     = key_info_q[KI_ACK];
                    mic     = key_info_q[KI_MIC];
                    install = key_info_q[KI_INSTALL];
                    secure  = key_info_q[KI_SECURE];
                    msg     = MSG_NONE;
                    if (i_is_data_packet && snap_ok_q &&
                        pos + 1 >= hdr + SNAP_LEN + EAPOL_MIN_LEN &&
                        eapol_kind_q == EAPOL_KEY_TYPE) begin
                        if (ack && !mic)                 msg = MSG_1;
                        else if (!ack && mic && !install) msg = MSG_2;
                        else if (ack && mic && install)  msg = MSG_3;
                        else if (!ack && mic && secure)  msg = MSG_4;
                    end

                    // Messages 1 and 3 travel from the access point to the station.
                    due.msg = msg;
                    due.ap  = '0;
                    due.sta = '0;
                    if (msg == MSG_1 || msg == MSG_3) begin
                        due.ap  = tx_addr_q;
                        due.sta = rx_addr_q;
                    end else if (msg != MSG_NONE) begin
                        due.ap  = rx_addr_q;
                        due.sta = tx_addr_q;
                    end
                    key_results_due = {key_results_due, due};
                    clear_frame();
                end
            end
            o_pending <= key_results_due.size();
        end
    end

endmodule

// ===== bench/tb.sv =====
`timescale 1ns / 1ps
// Top of the EAPOL-Key classifier bench: clock, reset, frame stimulus, result sink,
// watchdog and verdict. Depends on eakc_pkg, the classifier top and key_message_checker.

module tb;
    import eakc_pkg::*;

    localparam int HALF_PERIOD   = 5;
    localparam int RESET_CYCLES  = 10;
    localparam int HOLD_CYCLES   = 300;
    localparam int QUIET_LIMIT   = 2000;
    localparam int DRAIN_CYCLES  = 10;
    localparam int RANDOM_FRAMES = 12;
    localparam int CALM_FRAMES   = 4;

    // Key information bit positions and the RSN key descriptor type.
    localparam int         KI_INSTALL = 6;
    localparam int         KI_ACK     = 7;
    localparam int         KI_MIC     = 8;
    localparam int         KI_SECURE  = 9;
    localparam logic [7:0] RSN_DESC   = 8'd2;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        byte_valid = 1'b0;
    logic        byte_ready;
    logic [7:0]  frame_byte = 8'h00;
    logic        last_byte = 1'b0;
    logic        is_data = 1'b0;
    logic        res_valid;
    logic        res_ready = 1'b0;
    logic [2:0]  handshake_message;
    logic [47:0] ap_address;
    logic [47:0] station_address;
    int          pending;
    int          fail_count;
    int          quiet_cycles = 0;
    bit          tx_idle_on = 1'b1;
    bit          rx_idle_on = 1'b1;
    bit          hold_req = 1'b0;
    logic [7:0]  frame_bytes[$];

    always #HALF_PERIOD clk = ~clk;

    eapol_key_frame_classifier_top dut (
        .i_clk               (clk),
        .i_rst_n             (rst_n),
        .i_valid             (byte_valid),
        .o_ready             (byte_ready),
        .i_frame_byte        (frame_byte),
        .i_last_byte         (last_byte),
        .i_is_data_packet    (is_data),
        .o_valid             (res_valid),
        .i_ready             (res_ready),
        .o_handshake_message (handshake_message),
        .o_ap_address        (ap_address),
        .o_station_address   (station_address)
    );

    key_message_checker u_check (
        .i_clk               (clk),
        .i_rst_n             (rst_n),
        .i_byte_valid        (byte_valid),
        .i_byte_ready        (byte_ready),
        .i_frame_byte        (frame_byte),
        .i_last_byte         (last_byte),
        .i_is_data_packet    (is_data),
        .i_res_valid         (res_valid),
        .i_res_ready         (res_ready),
        .i_handshake_message (handshake_message),
        .i_ap_address        (ap_address),
        .i_station_address   (station_address),
        .o_pending           (pending),
        .o_fail_count        (fail_count)
    );

    function automatic logic [47:0] rand_addr();
        logic [63:0] r;
        r = {$urandom, $urandom};
        return r[47:0];
    endfunction

    // Adds one byte to the end of the frame being built.
    task automatic append_byte(input logic [7:0] b);
        frame_bytes = {frame_bytes, b};
    endtask

    // Random key information with the bits forced toward the wanted message.
    function automatic logic [15:0] make_key_info(input int want);
        logic [15:0] ki;
        ki = 16'($urandom);
        case (want)
            MSG_1: begin
                ki[KI_ACK] = 1'b1;
                ki[KI_MIC] = 1'b0;
            end
            MSG_2: begin
                ki[KI_ACK]     = 1'b0;
                ki[KI_MIC]     = 1'b1;
                ki[KI_INSTALL] = 1'b0;
            end
            MSG_3: begin
                ki[KI_ACK]     = 1'b1;
                ki[KI_MIC]     = 1'b1;
                ki[KI_INSTALL] = 1'b1;
            end
            MSG_4: begin
                ki[KI_ACK]     = 1'b0;
                ki[KI_MIC]     = 1'b1;
                ki[KI_INSTALL] = 1'b1;
                ki[KI_SECURE]  = 1'b1;
            end
            default: begin
                // Three bit patterns that decode to no message.
                case ($urandom_range(0, 2))
                    0: begin
                        ki[KI_ACK] = 1'b0;
                        ki[KI_MIC] = 1'b0;
                    end
                    1: begin
                        ki[KI_ACK]     = 1'b1;
                        ki[KI_MIC]     = 1'b1;
                        ki[KI_INSTALL] = 1'b0;
                    end
                    default: begin
                        ki[KI_ACK]     = 1'b0;
                        ki[KI_MIC]     = 1'b1;
                        ki[KI_INSTALL] = 1'b1;
                        ki[KI_SECURE]  = 1'b0;
                    end
                endcase
            end
        endcase
        return ki;
    endfunction

    // Builds a data frame carrying an EAPOL-Key body of eapol_len bytes after SNAP.
    // A snap_bad index from 0 to 7 corrupts that byte of the SNAP header.
    task automatic build_key_frame(input logic [1:0] ds, input bit qos,
                                   input logic [47:0] ra, input logic [47:0] ta,
                                   input logic [15:0] ki, input logic [7:0] kind,
                                   input int eapol_len, input int snap_bad);
        logic [7:0]  fc0;
        logic [7:0]  fc1;
        logic [7:0]  b;
        logic [7:0]  flip;
        logic [15:0] body_len;
        logic [63:0] snap;
        frame_bytes.delete();
        fc0 = 8'($urandom);
        fc1 = 8'($urandom);
        fc1[1:0] = ds;
        if (qos) begin
            fc0[7] = 1'b1;
            fc0[3] = 1'b1;
        end else if (fc0[7] && fc0[3]) begin
            fc0[7] = 1'b0;
        end
        append_byte(fc0);
        append_byte(fc1);
        repeat (2) append_byte(8'($urandom));
        for (int i = 5; i >= 0; i--) append_byte(ra[8 * i +: 8]);
        for (int i = 5; i >= 0; i--) append_byte(ta[8 * i +: 8]);
        // Third address and sequence control, then the optional fourth address and QoS.
        repeat (8) append_byte(8'($urandom));
        if (ds == 2'b11) repeat (HDR_ADDR4_ADD) append_byte(8'($urandom));
        if (qos) repeat (HDR_QOS_ADD) append_byte(8'($urandom));

        snap = 64'hAAAA_0300_0000_888E;
        for (int i = 0; i < SNAP_LEN; i++) begin
            b = snap[63 - 8 * i -: 8];
            if (i == snap_bad) begin
                flip = 8'($urandom_range(1, 255));
                b = b ^ flip;
            end
            append_byte(b);
        end

        body_len = 16'(eapol_len - 4);
        for (int i = 0; i < eapol_len; i++) begin
            case (i + SNAP_LEN)
                SNAP_LEN:              b = 8'($urandom_range(1, 2));
                EAPOL_TYPE_OFS:        b = kind;
                EAPOL_TYPE_OFS + 1:    b = body_len[15:8];
                EAPOL_TYPE_OFS + 2:    b = body_len[7:0];
                KEY_INFO_HI_OFS - 1:   b = RSN_DESC;
                KEY_INFO_HI_OFS:       b = ki[15:8];
                KEY_INFO_LO_OFS:       b = ki[7:0];
                default:               b = 8'($urandom);
            endcase
            append_byte(b);
        end
    endtask

    task automatic build_noise_frame(input int len);
        frame_bytes.delete();
        repeat (len) append_byte(8'($urandom));
    endtask

    // Sends the built frame one beat at a time. With jitter set, the data flag
    // wanders on every byte but the last one.
    task automatic send_frame(input logic dat, input bit jitter);
        int n;
        int gap;
        n = frame_bytes.size();
        for (int i = 0; i < n; i++) begin
            if (tx_idle_on && $urandom_range(0, 15) == 0) begin
                gap = $urandom_range(1, 12);
                byte_valid <= 1'b0;
                frame_byte <= 8'($urandom);
                last_byte  <= 1'($urandom_range(0, 1));
                repeat (gap) @(negedge clk);
            end
            byte_valid <= 1'b1;
            frame_byte <= frame_bytes[i];
            last_byte  <= (i == n - 1);
            is_data    <= (jitter && i != n - 1) ? 1'($urandom_range(0, 1)) : dat;
            @(posedge clk);
            while (!byte_ready) @(posedge clk);
            @(negedge clk);
        end
    endtask

    // Result sink: random stall bursts, plus one long hold-off on request.
    initial begin : result_sink
        int stall_left;
        int hold_left;
        stall_left = 0;
        hold_left  = 0;
        forever begin
            @(negedge clk);
            if (hold_req) begin
                hold_req  = 1'b0;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                res_ready <= 1'b0;
            end else if (stall_left > 0) begin
                stall_left--;
                res_ready <= 1'b0;
            end else if (rx_idle_on && $urandom_range(0, 5) == 0) begin
                stall_left = $urandom_range(1, 12) - 1;
                res_ready <= 1'b0;
            end else begin
                res_ready <= 1'b1;
            end
        end
    end

    // Watchdog on cycles in which neither channel moves a beat.
    always @(posedge clk) begin
        if (!rst_n || (byte_valid && byte_ready) || (res_valid && res_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= QUIET_LIMIT) begin
            $display("tb: FAIL");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin : stimulus
        logic [7:0] spare_byte;
        repeat (RESET_CYCLES) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Each message at the exact minimum length, with header lengths of 24, 26 and 32
        // bytes and extreme addresses; the data flag wanders during the third frame.
        build_key_frame(2'b00, 0, '1, '0, make_key_info(MSG_1), 8'(EAPOL_KEY_TYPE),
                        EAPOL_MIN_LEN, -1);
        send_frame(1'b1, 0);
        build_key_frame(2'b11, 1, '0, '1, make_key_info(MSG_2), 8'(EAPOL_KEY_TYPE),
                        EAPOL_MIN_LEN, -1);
        send_frame(1'b1, 0);
        build_key_frame(2'b01, 1, rand_addr(), rand_addr(), make_key_info(MSG_3),
                        8'(EAPOL_KEY_TYPE), EAPOL_MIN_LEN, -1);
        send_frame(1'b1, 1);
        build_key_frame(2'b10, 0, rand_addr(), rand_addr(), make_key_info(MSG_4),
                        8'(EAPOL_KEY_TYPE), EAPOL_MIN_LEN, -1);
        send_frame(1'b1, 0);

        // Single byte frame, a frame just under 28 bytes, one ending inside SNAP.
        build_noise_frame(1);
        send_frame(1'b1, 0);
        build_noise_frame(27);
        send_frame(1'b1, 1);
        build_key_frame(2'b00, 0, rand_addr(), rand_addr(), make_key_info(MSG_1),
                        8'(EAPOL_KEY_TYPE), EAPOL_MIN_LEN, -1);
        while (frame_bytes.size() > HDR_BASE + 4) spare_byte = frame_bytes.pop_back();
        send_frame(1'b1, 0);

        // Long sink hold-off while short frames keep coming, so the input backs up.
        hold_req = 1'b1;
        for (int k = 0; k < 8; k++) begin
            build_noise_frame($urandom_range(1, 4));
            send_frame(1'b1, 0);
        end
        byte_valid <= 1'b0;
        do @(negedge clk); while (pending != 0);

        // Short random frames, the tail without idling.
        for (int f = 0; f < RANDOM_FRAMES; f++) begin
            if (f == RANDOM_FRAMES - CALM_FRAMES) begin
                tx_idle_on = 1'b0;
                rx_idle_on = 1'b0;
            end
            build_noise_frame($urandom_range(1, 4));
            send_frame(1'($urandom_range(0, 1)), 1);
            // Now and then the sender waits for every result to come back.
            if (tx_idle_on && $urandom_range(0, 3) == 0) begin
                byte_valid <= 1'b0;
                do @(negedge clk); while (pending != 0);
            end
        end

        byte_valid <= 1'b0;
        do @(negedge clk); while (pending != 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (fail_count == 0)
            $display("tb: PASS");
        else
            $display("tb: FAIL");
        $finish;
    end

endmodule

// ===== files.f =====
+incdir+src
src/eakc_pkg.sv
src/eakc_tracker.sv
src/eakc_msg_decode.sv
src/eapol_key_frame_classifier_top.sv
bench/key_message_checker.sv
bench/tb.sv
